### rtl/lkv_pkg.sv
package lkv_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CAP_RESET = 16;
  localparam int OP_W      = 2;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CAP_W     = 5;
  localparam int OCC_W     = 5;

  typedef enum logic [OP_W-1:0] {
    OP_GET   = 2'd0,
    OP_PUT   = 2'd1,
    OP_ERASE = 2'd2
  } op_t;

  // What every cell does in the update cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TOUCH,
    CELL_REMOVE,
    CELL_INSERT
  } cell_op_t;

  typedef struct packed {
    logic             match;
    cell_op_t         op;
    logic             write_val;
    logic             do_evict;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

### rtl/lru_key_value_cache.sv
// Channel  Ports                                          Handshake
// request  in_operation, in_key, in_value                 start & !busy
// result   out_found, out_read_value, out_occupancy       out_valid, one cycle
// config   cfg_capacity                                   cfg_valid & cfg_ready
//
// A request is latched, then each cell compares its key, then the row is updated.
// The result strobe comes in the cycle after the update, and a new start is
// taken in that same cycle, so requests never overlap.
// Reset (rst_n low, synchronous) empties the store and sets capacity to 16.
// The receiver cannot stall; each result is shown for exactly one cycle.
module lru_key_value_cache #(
  parameter int DEPTH = lkv_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [lkv_pkg::OP_W-1:0]         in_operation,
  input  logic signed [lkv_pkg::KEY_W-1:0] in_key,
  input  logic signed [lkv_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  output logic                             out_found,
  output logic signed [lkv_pkg::VAL_W-1:0] out_read_value,
  output logic [lkv_pkg::OCC_W-1:0]        out_occupancy,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]        cfg_capacity
);
  import lkv_pkg::*;

  localparam int RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_APPLY} state_t;

  state_t            state_r;
  logic [OP_W-1:0]   op_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;
  logic [CAP_W-1:0]  cap_r;
  logic [CNT_W-1:0]  live_r, live_nxt;
  logic              out_valid_r;
  logic              out_found_r, out_found_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;

  cell_cmd_t         cmd;
  logic [RANK_W-1:0] lru_rank;
  logic [RANK_W-1:0] hit_rank;
  logic [VAL_W-1:0]  hit_value;
  logic              any_hit;
  logic [CMP_W-1:0]  cap_eff;
  logic [CMP_W-1:0]  live_ext;

  logic              cell_hit   [DEPTH];
  logic [RANK_W-1:0] cell_rank  [DEPTH];
  logic [VAL_W-1:0]  cell_value [DEPTH];
  logic [DEPTH-1:0]  taken;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_value_r;
  assign out_occupancy  = OCC_W'(live_r);

  assign lru_rank = RANK_W'(live_r - 1'b1);
  assign live_ext = CMP_W'(live_r);
  assign cap_eff  = (CMP_W'(cap_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_r);
  assign taken[0] = 1'b0;

  // Keys are unique among live entries, so at most one cell hits.
  always_comb begin
    any_hit   = 1'b0;
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_hit   = any_hit | cell_hit[i];
      hit_rank  = hit_rank | ({RANK_W{cell_hit[i]}} & cell_rank[i]);
      hit_value = hit_value | ({VAL_W{cell_hit[i]}} & cell_value[i]);
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.op        = CELL_HOLD;
    cmd.key       = key_r;
    cmd.value     = val_r;
    live_nxt      = live_r;
    out_found_nxt = 1'b0;
    out_value_nxt = '0;
    if (state_r == S_MATCH) begin
      cmd.match = 1'b1;
    end else if (state_r == S_APPLY) begin
      unique case (op_r)
        OP_GET: begin
          if (any_hit) begin
            cmd.op        = CELL_TOUCH;
            out_found_nxt = 1'b1;
            out_value_nxt = hit_value;
          end
        end
        OP_PUT: begin
          if (cap_eff != '0) begin
            if (any_hit) begin
              cmd.op        = CELL_TOUCH;
              cmd.write_val = 1'b1;
            end else begin
              cmd.op       = CELL_INSERT;
              cmd.do_evict = (live_ext >= cap_eff);
              if (!cmd.do_evict) live_nxt = live_r + 1'b1;
            end
          end
        end
        OP_ERASE: begin
          if (any_hit) begin
            cmd.op        = CELL_REMOVE;
            out_found_nxt = 1'b1;
            live_nxt      = live_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      lkv_cell #(.RANK_W(RANK_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .ref_rank (hit_rank),
        .lru_rank (lru_rank),
        .taken_in (taken[i]),
        .taken_out(),
        .hit      (cell_hit[i]),
        .rank     (cell_rank[i]),
        .value    (cell_value[i])
      );
    end else begin : g_mid
      lkv_cell #(.RANK_W(RANK_W)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .ref_rank (hit_rank),
        .lru_rank (lru_rank),
        .taken_in (taken[i]),
        .taken_out(taken[i+1]),
        .hit      (cell_hit[i]),
        .rank     (cell_rank[i]),
        .value    (cell_value[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_W'(CAP_RESET);
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) cap_r <= cfg_capacity;
      unique case (state_r)
        S_IDLE: begin
          if (start) state_r <= S_MATCH;
        end
        S_MATCH: state_r <= S_APPLY;
        S_APPLY: begin
          state_r     <= S_IDLE;
          live_r      <= live_nxt;
          out_valid_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (state_r == S_IDLE && start) begin
      op_r  <= in_operation;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (state_r == S_APPLY) begin
      out_found_r <= out_found_nxt;
      out_value_r <= out_value_nxt;
    end
  end

endmodule

### rtl/lkv_cell.sv
module lkv_cell #(
  parameter int RANK_W = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lkv_pkg::cell_cmd_t      cmd,
  input  logic [RANK_W-1:0]       ref_rank,
  input  logic [RANK_W-1:0]       lru_rank,
  input  logic                    taken_in,
  output logic                    taken_out,
  output logic                    hit,
  output logic [RANK_W-1:0]       rank,
  output logic [lkv_pkg::VAL_W-1:0] value
);
  import lkv_pkg::*;

  logic              valid_r, valid_nxt;
  logic              hit_r;
  logic              evict_r;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              free;
  logic              chosen;

  // A slot is free if empty or being evicted; the first free one down the row takes the insert.
  assign free      = !valid_r || (cmd.do_evict && evict_r);
  assign chosen    = free && !taken_in;
  assign taken_out = taken_in || free;

  assign hit   = hit_r;
  assign rank  = rank_r;
  assign value = val_r;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    rank_nxt  = rank_r;
    unique case (cmd.op)
      CELL_TOUCH: begin
        if (hit_r) begin
          rank_nxt = '0;
          if (cmd.write_val) val_nxt = cmd.value;
        end else if (valid_r && rank_r < ref_rank) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      CELL_REMOVE: begin
        if (hit_r) begin
          valid_nxt = 1'b0;
        end else if (valid_r && rank_r > ref_rank) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      CELL_INSERT: begin
        if (chosen) begin
          valid_nxt = 1'b1;
          key_nxt   = cmd.key;
          val_nxt   = cmd.value;
          rank_nxt  = '0;
        end else if (free) begin
          valid_nxt = 1'b0;
        end else begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      CELL_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
      evict_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cmd.match) begin
        hit_r   <= valid_r && (key_r == cmd.key);
        evict_r <= valid_r && (rank_r == lru_rank);
      end
    end
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    rank_r <= rank_nxt;
  end

endmodule

### rtl/lkv_checker.sv
module lkv_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic                             out_found,
  input logic signed [lkv_pkg::VAL_W-1:0] out_read_value
);

  // A taken request is answered by the result strobe after the compare and update states.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result strobe missing three cycles after request");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_read_value == '0))
    else $error("nonzero read value without a hit");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_found     (out_found),
  .out_read_value(out_read_value)
);
